// ===== hw/rtl/ccpl_pkg.sv =====
`timescale 1ns / 1ps

package ccpl_pkg;

	localparam int WINDOW      = 32;
	localparam int SAMPLE_BITS = 12;

	localparam int LAG_BITS  = 5;
	localparam int SUM_BITS  = 29;
	localparam int CFG_BITS  = 6;
	localparam int CNT_BITS  = 6;
	localparam int IDX_BITS  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int PROD_BITS = 2 * SAMPLE_BITS;
	localparam int ACC_EXT_BITS = ((PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS) + 1;
	localparam int ADDR_SUM_BITS = ((CNT_BITS > IDX_BITS) ? CNT_BITS : IDX_BITS) + 1;

	localparam int LAGS_LIMIT = (WINDOW < 32) ? WINDOW : 32;

	localparam logic [SUM_BITS-1:0] SUM_MAX     = '1;
	localparam logic [CFG_BITS-1:0] LAGS_RESET  = CFG_BITS'(32);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_a;
		logic [SAMPLE_BITS-1:0] sample_b;
	} samp_t;

	typedef struct packed {
		logic [LAG_BITS-1:0] peak_lag;
		logic [SUM_BITS-1:0] peak_sum;
	} peak_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

// ===== hw/rtl/ccpl_window_mem.sv =====
`timescale 1ns / 1ps

module ccpl_window_mem (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [ccpl_pkg::IDX_BITS-1:0]    wr_addr,
	input  ccpl_pkg::samp_t                  wr_data,
	input  logic [ccpl_pkg::IDX_BITS-1:0]    rd_addr_a,
	input  logic [ccpl_pkg::IDX_BITS-1:0]    rd_addr_b,
	output logic [ccpl_pkg::SAMPLE_BITS-1:0] rd_a,
	output logic [ccpl_pkg::SAMPLE_BITS-1:0] rd_b
);

	logic [ccpl_pkg::SAMPLE_BITS-1:0] mem_a [ccpl_pkg::WINDOW];
	logic [ccpl_pkg::SAMPLE_BITS-1:0] mem_b [ccpl_pkg::WINDOW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= wr_data.sample_a;
			mem_b[wr_addr] <= wr_data.sample_b;
		end
		rd_a <= mem_a[rd_addr_a];
		rd_b <= mem_b[rd_addr_b];
	end

endmodule

// ===== hw/rtl/ccpl_mac.sv =====
`timescale 1ns / 1ps

module ccpl_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ccpl_pkg::mac_ctl_t               ctl,
	input  logic [ccpl_pkg::SAMPLE_BITS-1:0] a,
	input  logic [ccpl_pkg::SAMPLE_BITS-1:0] b,
	output logic                             done,
	output logic [ccpl_pkg::SUM_BITS-1:0]    sum
);

	ccpl_pkg::mac_ctl_t                  ctl_s2;
	logic [ccpl_pkg::PROD_BITS-1:0]      prod_s2;
	logic [ccpl_pkg::SUM_BITS-1:0]       acc_q;
	logic                                done_q;
	logic [ccpl_pkg::ACC_EXT_BITS-1:0]   acc_ext;
	logic [ccpl_pkg::SUM_BITS-1:0]       acc_next;

	always_comb begin
		acc_ext = ctl_s2.first ? '0 : ccpl_pkg::ACC_EXT_BITS'(acc_q);
		acc_ext = acc_ext + ccpl_pkg::ACC_EXT_BITS'(prod_s2);
		// saturate at the top of the result range
		if (acc_ext > ccpl_pkg::ACC_EXT_BITS'(ccpl_pkg::SUM_MAX)) begin
			acc_next = ccpl_pkg::SUM_MAX;
		end else begin
			acc_next = acc_ext[ccpl_pkg::SUM_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ccpl_pkg::PROD_BITS'(a) * ccpl_pkg::PROD_BITS'(b);
		if (ctl_s2.valid) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	assign done = done_q;
	assign sum  = acc_q;

endmodule

// ===== hw/rtl/cross_correlation_peak_lag_unit.sv =====
`timescale 1ns / 1ps

// cross-correlation peak finder over a window of sample pairs
// samp channel (valid/stall): one pair of samples per transaction; the pairs
// fill a window of WINDOW entries, and the last pair of a window starts the search
// peak channel (valid/stall): one transaction per window, the first lag with the
// largest correlation sum and that sum
// cfg channel (valid/ready, always ready): writes lags_in_use at any time; the value
// present when a window closes is the one searched
// a sample that does not close a window is accepted whenever no search is running
// the closing sample starts a search on one shared multiply-accumulate unit:
// one term per cycle, sum over lags of (WINDOW - lag) terms, passed through the
// read, multiply and accumulate registers; with 32 lags and a 32 entry window
// the search covers 528 terms, with no lags searched the result shows next cycle
// samp_stall is high during the search
// the result waits in an output register while peak_stall is high; samples keep
// being taken then, except one that would close the next window
// reset clears the window fill count, the sequencer and lags_in_use (to 32);
// window contents are not cleared, a window is always full before it is read

module cross_correlation_peak_lag_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          samp_valid,
	output logic                          samp_stall,
	input  ccpl_pkg::samp_t               samp,
	output logic                          peak_valid,
	input  logic                          peak_stall,
	output ccpl_pkg::peak_t               peak,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ccpl_pkg::CFG_BITS-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_OUT
	} state_t;

	state_t                                state_q;
	logic [ccpl_pkg::CFG_BITS-1:0]         lags_cfg_q;
	logic [ccpl_pkg::IDX_BITS-1:0]         fill_q;
	logic [ccpl_pkg::CNT_BITS-1:0]         lags_q;
	logic [ccpl_pkg::CNT_BITS-1:0]         lag_q;
	logic [ccpl_pkg::CNT_BITS-1:0]         cmp_lag_q;
	logic [ccpl_pkg::IDX_BITS-1:0]         j_q;
	logic                                  issuing_q;
	logic [ccpl_pkg::SUM_BITS-1:0]         best_sum_q;
	logic [ccpl_pkg::LAG_BITS-1:0]         best_lag_q;
	ccpl_pkg::peak_t                       peak_q;
	ccpl_pkg::mac_ctl_t                    ctl_s1;
	ccpl_pkg::mac_ctl_t                    issue_ctl;

	logic                                  samp_acc;
	logic                                  closes;
	logic [ccpl_pkg::CNT_BITS-1:0]         lags_eff;
	logic [ccpl_pkg::ADDR_SUM_BITS-1:0]    addr_sum;
	logic [ccpl_pkg::SAMPLE_BITS-1:0]      rd_a;
	logic [ccpl_pkg::SAMPLE_BITS-1:0]      rd_b;
	logic                                  mac_done;
	logic [ccpl_pkg::SUM_BITS-1:0]         mac_sum;
	logic [ccpl_pkg::SUM_BITS-1:0]         nb_sum;
	logic [ccpl_pkg::LAG_BITS-1:0]         nb_lag;

	assign closes     = (fill_q == ccpl_pkg::IDX_BITS'(ccpl_pkg::WINDOW - 1));
	assign samp_stall = (state_q == ST_CALC) || ((state_q == ST_OUT) && closes);
	assign samp_acc   = samp_valid && !samp_stall;
	assign cfg_ready  = 1'b1;
	assign peak_valid = (state_q == ST_OUT);
	assign peak       = peak_q;

	always_comb begin
		if (ccpl_pkg::CNT_BITS'(lags_cfg_q) > ccpl_pkg::CNT_BITS'(ccpl_pkg::LAGS_LIMIT)) begin
			lags_eff = ccpl_pkg::CNT_BITS'(ccpl_pkg::LAGS_LIMIT);
		end else begin
			lags_eff = ccpl_pkg::CNT_BITS'(lags_cfg_q);
		end
	end

	// term j of lag pairs a[j] with b[j + lag]
	assign addr_sum        = ccpl_pkg::ADDR_SUM_BITS'(j_q) + ccpl_pkg::ADDR_SUM_BITS'(lag_q);
	assign issue_ctl.valid = (state_q == ST_CALC) && issuing_q;
	assign issue_ctl.first = (j_q == '0);
	assign issue_ctl.last  = (addr_sum == ccpl_pkg::ADDR_SUM_BITS'(ccpl_pkg::WINDOW - 1));

	always_comb begin
		nb_sum = best_sum_q;
		nb_lag = best_lag_q;
		if (mac_sum > best_sum_q) begin
			nb_sum = mac_sum;
			nb_lag = cmp_lag_q[ccpl_pkg::LAG_BITS-1:0];
		end
	end

	ccpl_window_mem u_mem (
		.clk       (clk),
		.wr_en     (samp_acc),
		.wr_addr   (fill_q),
		.wr_data   (samp),
		.rd_addr_a (j_q),
		.rd_addr_b (addr_sum[ccpl_pkg::IDX_BITS-1:0]),
		.rd_a      (rd_a),
		.rd_b      (rd_b)
	);

	ccpl_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.a      (rd_a),
		.b      (rd_b),
		.done   (mac_done),
		.sum    (mac_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lags_cfg_q <= ccpl_pkg::LAGS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			lags_cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (samp_acc) begin
			fill_q <= closes ? '0 : fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= issue_ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			lags_q     <= '0;
			lag_q      <= '0;
			cmp_lag_q  <= '0;
			j_q        <= '0;
			issuing_q  <= 1'b0;
			best_sum_q <= '0;
			best_lag_q <= '0;
			peak_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE, ST_OUT: begin
					if (state_q == ST_OUT && !peak_stall) begin
						state_q <= ST_IDLE;
					end
					if (samp_acc && closes) begin
						lags_q     <= lags_eff;
						lag_q      <= '0;
						cmp_lag_q  <= '0;
						j_q        <= '0;
						best_sum_q <= '0;
						best_lag_q <= '0;
						if (lags_eff == '0) begin
							peak_q  <= '0;
							state_q <= ST_OUT;
						end else begin
							issuing_q <= 1'b1;
							state_q   <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					if (issue_ctl.valid) begin
						if (issue_ctl.last) begin
							j_q <= '0;
							if (lag_q + 1'b1 == lags_q) begin
								issuing_q <= 1'b0;
							end else begin
								lag_q <= lag_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
					if (mac_done) begin
						best_sum_q <= nb_sum;
						best_lag_q <= nb_lag;
						cmp_lag_q  <= cmp_lag_q + 1'b1;
						if (cmp_lag_q + 1'b1 == lags_q) begin
							peak_q.peak_lag <= nb_lag;
							peak_q.peak_sum <= nb_sum;
							state_q         <= ST_OUT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/ccpl_checker.sv =====
`timescale 1ns / 1ps

module ccpl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          samp_valid,
	input logic                          samp_stall,
	input ccpl_pkg::samp_t               samp,
	input logic                          peak_valid,
	input logic                          peak_stall,
	input ccpl_pkg::peak_t               peak
);

	// a waiting result holds
	a_peak_hold: assert property (@(posedge clk) disable iff (!arst_n)
		peak_valid && peak_stall |=> peak_valid && $stable(peak))
		else $error("peak changed while stalled");

	// a stalled sample pair holds
	a_samp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		samp_valid && samp_stall |=> samp_valid && $stable(samp))
		else $error("sample changed while stalled");

	// an all-zero peak must report lag zero
	a_zero_lag: assert property (@(posedge clk) disable iff (!arst_n)
		peak_valid && (peak.peak_sum == '0) |-> (peak.peak_lag == '0))
		else $error("zero peak with nonzero lag");

	// a result appears only after a closing sample or a search
	a_peak_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(peak_valid) |-> $past(samp_valid) || $past(samp_stall))
		else $error("result without a cause");

	// one result per window
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$past(peak_valid && !peak_stall) |-> !peak_valid)
		else $error("result repeated");

endmodule

bind cross_correlation_peak_lag_unit ccpl_checker u_ccpl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.samp_valid (samp_valid),
	.samp_stall (samp_stall),
	.samp       (samp),
	.peak_valid (peak_valid),
	.peak_stall (peak_stall),
	.peak       (peak)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int SEARCH_CYCLES = 600;
	localparam int QUIET_LIMIT   = 20000;
	localparam int HOLD_CYCLES   = 3000;
	localparam int RANDOM_ITEMS  = 880;
	localparam int S_TOP         = (1 << ccpl_pkg::SAMPLE_BITS) - 1;
	localparam logic [ccpl_pkg::SAMPLE_BITS-1:0] S_MAX = '1;

	typedef enum {PAT_UNIFORM, PAT_DELAYED, PAT_SPARSE, PAT_TINY, PAT_FLAT} pat_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic samp_valid;
	logic samp_stall;
	ccpl_pkg::samp_t samp;
	logic peak_valid;
	logic peak_stall;
	ccpl_pkg::peak_t peak;
	logic cfg_valid;
	logic cfg_ready;
	logic [ccpl_pkg::CFG_BITS-1:0] cfg_data;

	// shadow of the block: window contents, fill position and lag count
	logic [ccpl_pkg::SAMPLE_BITS-1:0] win_a [ccpl_pkg::WINDOW];
	logic [ccpl_pkg::SAMPLE_BITS-1:0] win_b [ccpl_pkg::WINDOW];
	int win_fill = 0;
	logic [ccpl_pkg::CFG_BITS-1:0] lags_now = ccpl_pkg::LAGS_RESET;
	ccpl_pkg::peak_t pending_peaks[$];
	ccpl_pkg::peak_t want;

	ccpl_pkg::samp_t pat [ccpl_pkg::WINDOW];
	bit tx_gaps = 1'b0;
	bit rx_gaps = 1'b0;
	int hold_req = 0;
	int errors = 0;
	int quiet = 0;
	int items_sent = 0;

	cross_correlation_peak_lag_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samp_valid(samp_valid),
		.samp_stall(samp_stall),
		.samp(samp),
		.peak_valid(peak_valid),
		.peak_stall(peak_stall),
		.peak(peak),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// first strictly largest sum over the searched lags
	function automatic ccpl_pkg::peak_t find_peak();
		longint unsigned acc;
		longint unsigned best;
		int best_lag;
		int n;
		ccpl_pkg::peak_t r;
		n = lags_now;
		if (n > ccpl_pkg::LAGS_LIMIT)
			n = ccpl_pkg::LAGS_LIMIT;
		best = 0;
		best_lag = 0;
		for (int lag = 0; lag < n; lag++) begin
			acc = 0;
			for (int j = 0; j + lag < ccpl_pkg::WINDOW; j++) begin
				acc += longint'(win_a[j]) * longint'(win_b[j + lag]);
				if (acc > ccpl_pkg::SUM_MAX)
					acc = ccpl_pkg::SUM_MAX;
			end
			if (acc > best) begin
				best = acc;
				best_lag = lag;
			end
		end
		r.peak_lag = best_lag[ccpl_pkg::LAG_BITS-1:0];
		r.peak_sum = best[ccpl_pkg::SUM_BITS-1:0];
		return r;
	endfunction

	task automatic take_pair(input ccpl_pkg::samp_t s);
		win_a[win_fill] = s.sample_a;
		win_b[win_fill] = s.sample_b;
		win_fill++;
		if (win_fill == ccpl_pkg::WINDOW) begin
			win_fill = 0;
			pending_peaks.push_back(find_peak());
		end
	endtask

	task automatic send_pair(input ccpl_pkg::samp_t s);
		int gap;
		int r;
		@(negedge clk);
		samp_valid <= 1'b1;
		samp <= s;
		do @(posedge clk); while (samp_stall !== 1'b0);
		take_pair(s);
		items_sent++;
		gap = 0;
		if (tx_gaps) begin
			r = $urandom_range(99, 0);
			if (r >= 95)
				gap = $urandom_range(80, 10);
			else if (r >= 60)
				gap = $urandom_range(3, 1);
		end
		if (gap > 0) begin
			@(negedge clk);
			samp_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_noise(input int n);
		ccpl_pkg::samp_t s;
		repeat (n) begin
			s.sample_a = ccpl_pkg::SAMPLE_BITS'($urandom_range(S_TOP, 0));
			s.sample_b = ccpl_pkg::SAMPLE_BITS'($urandom_range(S_TOP, 0));
			send_pair(s);
		end
	endtask

	task automatic sender_rest();
		@(negedge clk);
		samp_valid <= 1'b0;
	endtask

	task automatic wait_results();
		sender_rest();
		while (pending_peaks.size() != 0) @(posedge clk);
	endtask

	// lags_in_use is only written with nothing in flight
	task automatic write_lags(input int v);
		wait_results();
		repeat (SEARCH_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= ccpl_pkg::CFG_BITS'(v);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		lags_now = ccpl_pkg::CFG_BITS'(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic clear_pattern();
		for (int j = 0; j < ccpl_pkg::WINDOW; j++)
			pat[j] = '0;
	endtask

	task automatic make_pattern(input pat_kind_t kind);
		int d;
		int v;
		d = $urandom_range(ccpl_pkg::WINDOW - 1, 0);
		case ($urandom_range(2, 0))
		0: v = 0;
		1: v = S_TOP;
		default: v = $urandom_range(S_TOP, 0);
		endcase
		for (int j = 0; j < ccpl_pkg::WINDOW; j++) begin
			case (kind)
			PAT_UNIFORM, PAT_DELAYED: begin
				pat[j].sample_a = ccpl_pkg::SAMPLE_BITS'($urandom_range(S_TOP, 0));
				pat[j].sample_b = (kind == PAT_DELAYED)
					? ccpl_pkg::SAMPLE_BITS'($urandom_range(63, 0))
					: ccpl_pkg::SAMPLE_BITS'($urandom_range(S_TOP, 0));
			end
			PAT_SPARSE: begin
				pat[j].sample_a = ($urandom_range(7, 0) == 0)
					? ccpl_pkg::SAMPLE_BITS'($urandom_range(S_TOP, 0)) : '0;
				pat[j].sample_b = ($urandom_range(7, 0) == 0)
					? ccpl_pkg::SAMPLE_BITS'($urandom_range(S_TOP, 0)) : '0;
			end
			PAT_TINY: begin
				pat[j].sample_a = ccpl_pkg::SAMPLE_BITS'($urandom_range(2, 0));
				pat[j].sample_b = ccpl_pkg::SAMPLE_BITS'($urandom_range(2, 0));
			end
			default: begin
				pat[j].sample_a = ccpl_pkg::SAMPLE_BITS'(v);
				pat[j].sample_b = ccpl_pkg::SAMPLE_BITS'(v);
			end
			endcase
		end
		// channel b carries channel a shifted by d samples
		if (kind == PAT_DELAYED)
			for (int j = 0; j + d < ccpl_pkg::WINDOW; j++)
				pat[j + d].sample_b = pat[j].sample_a;
	endtask

	// finishes the current window from the pattern position it has reached
	task automatic send_tail();
		int start;
		start = win_fill;
		for (int i = start; i < ccpl_pkg::WINDOW; i++)
			send_pair(pat[i]);
	endtask

	task automatic test_extremes();
		for (int j = 0; j < ccpl_pkg::WINDOW; j++)
			pat[j] = {S_MAX, S_MAX};
		send_tail();
		clear_pattern();
		send_tail();
		for (int j = 0; j < ccpl_pkg::WINDOW; j++) begin
			pat[j].sample_a = j[0] ? 12'hAAA : 12'h555;
			pat[j].sample_b = j[0] ? 12'h555 : 12'hAAA;
		end
		send_tail();
		for (int j = 0; j < ccpl_pkg::WINDOW; j++)
			pat[j] = {S_MAX, {ccpl_pkg::SAMPLE_BITS{1'b0}}};
		send_tail();
	endtask

	task automatic test_first_peak_wins();
		// equal sums at lags 5 and 12
		clear_pattern();
		pat[0].sample_a = ccpl_pkg::SAMPLE_BITS'(1);
		pat[5].sample_b = ccpl_pkg::SAMPLE_BITS'(7);
		pat[12].sample_b = ccpl_pkg::SAMPLE_BITS'(7);
		send_tail();
		// only the last lag sees anything
		clear_pattern();
		pat[0].sample_a = S_MAX;
		pat[ccpl_pkg::WINDOW - 1].sample_b = S_MAX;
		send_tail();
	endtask

	task automatic test_lag_settings();
		write_lags(0);
		make_pattern(PAT_UNIFORM);
		send_tail();
		write_lags(1);
		make_pattern(PAT_DELAYED);
		send_tail();
		clear_pattern();
		pat[0].sample_a = S_MAX;
		pat[ccpl_pkg::WINDOW - 1].sample_b = S_MAX;
		write_lags(63);
		send_tail();
		write_lags(33);
		send_tail();
		write_lags(31);
		send_tail();
	endtask

	task automatic test_midwindow_write();
		write_lags(32);
		clear_pattern();
		pat[0].sample_a = S_MAX;
		pat[ccpl_pkg::WINDOW - 1].sample_b = S_MAX;
		pat[1].sample_a = ccpl_pkg::SAMPLE_BITS'(3);
		pat[1].sample_b = ccpl_pkg::SAMPLE_BITS'(3);
		for (int i = 0; i < 10; i++)
			send_pair(pat[i]);
		// the count present when the window closes is the one used
		write_lags(1);
		send_tail();
	endtask

	task automatic test_backpressure();
		write_lags(32);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_req = HOLD_CYCLES;
		repeat (3) begin
			make_pattern(PAT_UNIFORM);
			send_tail();
		end
		wait_results();
	endtask

	task automatic test_sender_pause();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		make_pattern(PAT_DELAYED);
		send_tail();
		wait_results();
		repeat ($urandom_range(50, 1)) @(negedge clk);
		make_pattern(PAT_UNIFORM);
		send_tail();
	endtask

	task automatic test_random();
		int start;
		int v;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			case ($urandom_range(9, 0))
			0: v = 0;
			1: v = 1;
			2: v = 63;
			3, 4: v = 32;
			default: v = $urandom_range(63, 0);
			endcase
			write_lags(v);
			tx_gaps = ($urandom_range(3, 0) != 0);
			rx_gaps = ($urandom_range(3, 0) != 0);
			repeat ($urandom_range(3, 1)) begin
				if ($urandom_range(9, 0) == 0) begin
					send_noise($urandom_range(40, 1));
				end else begin
					make_pattern(pat_kind_t'($urandom_range(4, 0)));
					send_tail();
				end
			end
		end
	endtask

	initial begin
		samp_valid = 1'b0;
		samp = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_first_peak_wins();
		test_lag_settings();
		test_midwindow_write();
		test_backpressure();
		test_sender_pause();
		test_random();
		wait_results();
		repeat (SEARCH_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// result side stall, with long holds on request
	initial begin : rx_side
		int stall_left;
		stall_left = 0;
		peak_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end else if (stall_left == 0 && rx_gaps && $urandom_range(7, 0) == 0) begin
				stall_left = ($urandom_range(9, 0) == 0) ? $urandom_range(150, 20)
					: $urandom_range(4, 1);
			end
			if (stall_left > 0) begin
				stall_left--;
				peak_stall <= 1'b1;
			end else begin
				peak_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && peak_valid === 1'b1 && !peak_stall) begin
			if (pending_peaks.size() == 0) begin
				$display("%0t ns: unexpected transaction: lag %0d sum %0d", $time,
					peak.peak_lag, peak.peak_sum);
				errors++;
			end else begin
				want = pending_peaks.pop_front();
				if (peak.peak_lag !== want.peak_lag) begin
					$display("%0t ns: peak_lag expected %0d actual %0d", $time,
						want.peak_lag, peak.peak_lag);
					errors++;
				end
				if (peak.peak_sum !== want.peak_sum) begin
					$display("%0t ns: peak_sum expected %0d actual %0d", $time,
						want.peak_sum, peak.peak_sum);
					errors++;
				end
			end
		end
	end

	// no transaction on any channel for too long
	always @(posedge clk) begin
		if ((samp_valid && samp_stall === 1'b0) || (peak_valid === 1'b1 && !peak_stall)
				|| (cfg_valid && cfg_ready === 1'b1))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/ccpl_pkg.sv
hw/rtl/ccpl_window_mem.sv
hw/rtl/ccpl_mac.sv
hw/rtl/cross_correlation_peak_lag_unit.sv
hw/rtl/ccpl_checker.sv
verif/testbench.sv
